// ===== rtl/linear_probe_hash_table_core_defines.svh =====
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

// Checks that hold at every clock edge outside reset.
`define LPHT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("lpht check failed");

// Checks that relate one cycle to the next.
`define LPHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht sequence check failed");

`endif

// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

  localparam int MAX_CAPACITY_DEF     = 256;
  localparam int INITIAL_CAPACITY_DEF = 8;
  localparam int KEY_WIDTH_DEF        = 64;
  localparam int VALUE_WIDTH_DEF      = 64;
  localparam int HASH_WIDTH           = 32;
  localparam int LOAD_WIDTH           = 7;
  localparam logic [LOAD_WIDTH-1:0] LOAD_RESET = 7'd75;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== rtl/lpht_mem.sv =====
module lpht_mem #(
  parameter int AW = 9,
  parameter int DW = 160
) (
  input  logic                 clk,
  input  lpht_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]        waddr,
  input  logic [DW-1:0]        wdata,
  input  logic [AW-1:0]        raddr,
  output logic [DW-1:0]        rdata
);
  import lpht_pkg::*;

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/linear_probe_hash_table_core.sv =====
// Channel | Direction | Handshake        | Word
// in      | input     | in_valid/in_stall | req_type, key_word, key_hash, value_in
// out     | output    | out_valid/out_stall | key_found, value_out, status
// cfg     | input     | cfg_valid/cfg_ready | load_percent
//
// A get or put passes through START, LOOK, then a PRB_RD/PRB_CMP pair per slot probed, then
// DONE before its result is registered; the next word is taken once the core is back in IDLE.
// A put that grows the table first reads every old slot, then for each moved entry probes the
// new half slot by slot, then switches halves, all paced by the single read port of the slot
// memory. Reset is synchronous and restores capacity, count and load; a clearing pass then
// empties every one of the 2 * MAX_CAPACITY slots with in_stall high.
// A new word is taken while a result waits under out_stall.
`include "linear_probe_hash_table_core_defines.svh"

module linear_probe_hash_table_core #(
  parameter int MAX_CAPACITY     = lpht_pkg::MAX_CAPACITY_DEF,
  parameter int INITIAL_CAPACITY = lpht_pkg::INITIAL_CAPACITY_DEF,
  parameter int KEY_WIDTH        = lpht_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH      = lpht_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  logic [KEY_WIDTH-1:0]               in_key_word,
  input  logic [lpht_pkg::HASH_WIDTH-1:0]    in_key_hash,
  input  logic [VALUE_WIDTH-1:0]             in_value_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_key_found,
  output logic [VALUE_WIDTH-1:0]             out_value_out,
  output logic                               out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpht_pkg::LOAD_WIDTH-1:0]    cfg_data
);
  import lpht_pkg::*;

  localparam int AW = $clog2(MAX_CAPACITY);
  localparam int CW = AW + 1;
  localparam int EW = 1 + KEY_WIDTH + VALUE_WIDTH + HASH_WIDTH;
  localparam int PW = CW + LOAD_WIDTH;
  localparam int NSLOT = 2 * MAX_CAPACITY;

  typedef enum logic [10:0] {
    ST_CLR     = 11'b00000000001,
    ST_IDLE    = 11'b00000000010,
    ST_START   = 11'b00000000100,
    ST_GR_RD   = 11'b00000001000,
    ST_GR_HASH = 11'b00000010000,
    ST_GR_PRB  = 11'b00000100000,
    ST_GR_CHK  = 11'b00001000000,
    ST_LOOK    = 11'b00010000000,
    ST_PRB_RD  = 11'b00100000000,
    ST_PRB_CMP = 11'b01000000000,
    ST_DONE    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [LOAD_WIDTH-1:0] load_r;
  logic [CW-1:0] cap_r, cap_nxt, count_r, count_nxt, n_r, n_nxt, i_r, i_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic bank_r, bank_nxt;
  logic [EW-1:0] ent_r;
  logic req_type_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [HASH_WIDTH-1:0] hash_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic res_found_r, res_found_nxt, res_status_r, res_status_nxt;
  logic [VALUE_WIDTH-1:0] res_val_r, res_val_nxt;
  logic out_valid_r, out_found_r, out_status_r;
  logic [VALUE_WIDTH-1:0] out_value_r;

  mem_ctl_t mctl;
  logic [AW:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic rd_valid;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [HASH_WIDTH-1:0] rd_hash;

  logic [AW-1:0] mask, new_mask;
  logic [PW-1:0] load_lhs, load_rhs;
  logic grow;

  assign rd_valid = rdata[EW-1];
  assign rd_key   = rdata[EW-2 -: KEY_WIDTH];
  assign rd_val   = rdata[HASH_WIDTH +: VALUE_WIDTH];
  assign rd_hash  = rdata[HASH_WIDTH-1:0];

  assign mask     = AW'(cap_r - CW'(1));
  assign new_mask = AW'((cap_r << 1) - CW'(1));
  assign load_lhs = (PW'(count_r) + PW'(1)) * PW'(100);
  assign load_rhs = PW'(cap_r) * PW'(load_r);
  assign grow     = (load_lhs > load_rhs) && (cap_r <= CW'(MAX_CAPACITY / 2));

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  lpht_mem #(.AW(AW + 1), .DW(EW)) u_mem (
    .clk  (clk),
    .ctl  (mctl),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    idx_nxt        = idx_r;
    bank_nxt       = bank_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    mctl           = '0;
    waddr          = {bank_r, idx_r};
    raddr          = {bank_r, idx_r};
    wdata          = {1'b1, key_r, val_r, hash_r};
    unique case (state_r)
      ST_CLR: begin
        mctl.we = 1'b1;
        waddr   = i_r;
        wdata   = '0;
        if (i_r == CW'(NSLOT - 1)) begin
          i_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        res_found_nxt  = 1'b0;
        res_status_nxt = 1'b0;
        res_val_nxt    = '0;
        i_nxt          = '0;
        if (req_type_r == REQ_PUT && grow) begin
          state_nxt = ST_GR_RD;
        end else begin
          state_nxt = ST_LOOK;
        end
      end
      ST_GR_RD: begin
        raddr = {bank_r, i_r[AW-1:0]};
        if (i_r == cap_r) begin
          bank_nxt  = ~bank_r;
          cap_nxt   = cap_r << 1;
          state_nxt = ST_LOOK;
        end else begin
          mctl.re   = 1'b1;
          state_nxt = ST_GR_HASH;
        end
      end
      ST_GR_HASH: begin
        if (!rd_valid) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_GR_RD;
        end else begin
          mctl.we   = 1'b1;
          waddr     = {bank_r, i_r[AW-1:0]};
          wdata     = '0;
          idx_nxt   = rd_hash[AW-1:0] & new_mask;
          state_nxt = ST_GR_PRB;
        end
      end
      ST_GR_PRB: begin
        raddr     = {~bank_r, idx_r};
        mctl.re   = 1'b1;
        state_nxt = ST_GR_CHK;
      end
      ST_GR_CHK: begin
        if (rd_valid) begin
          idx_nxt   = (idx_r + AW'(1)) & new_mask;
          state_nxt = ST_GR_PRB;
        end else begin
          mctl.we   = 1'b1;
          waddr     = {~bank_r, idx_r};
          wdata     = ent_r;
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_GR_RD;
        end
      end
      ST_LOOK: begin
        idx_nxt   = hash_r[AW-1:0] & mask;
        n_nxt     = '0;
        state_nxt = ST_PRB_RD;
      end
      ST_PRB_RD: begin
        mctl.re   = 1'b1;
        state_nxt = ST_PRB_CMP;
      end
      ST_PRB_CMP: begin
        if (!rd_valid) begin
          if (req_type_r == REQ_PUT) begin
            mctl.we   = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          state_nxt = ST_DONE;
        end else if (rd_key == key_r) begin
          res_found_nxt = 1'b1;
          if (req_type_r == REQ_PUT) begin
            mctl.we = 1'b1;
            wdata   = {1'b1, key_r, val_r, rd_hash};
          end else begin
            res_val_nxt = rd_val;
          end
          state_nxt = ST_DONE;
        end else if (n_r + CW'(1) == cap_r) begin
          res_status_nxt = (req_type_r == REQ_PUT);
          state_nxt      = ST_DONE;
        end else begin
          n_nxt     = n_r + CW'(1);
          idx_nxt   = (idx_r + AW'(1)) & mask;
          state_nxt = ST_PRB_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      load_r      <= LOAD_RESET;
      cap_r       <= CW'(INITIAL_CAPACITY);
      count_r     <= '0;
      bank_r      <= 1'b0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
      i_r     <= i_nxt;
      if (cfg_valid && cfg_ready) begin
        load_r <= cfg_data;
      end
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    if (state_r == ST_GR_HASH) begin
      ent_r <= rdata;
    end
    if (in_valid && !in_stall) begin
      req_type_r <= in_req_type;
      key_r      <= in_key_word;
      hash_r     <= in_key_hash;
      val_r      <= in_value_in;
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_found_r  <= res_found_r;
      out_value_r  <= res_val_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_found = out_found_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  `LPHT_ASSERT_ALWAYS(a_count_fits, count_r <= cap_r)
  `LPHT_ASSERT_ALWAYS(a_cap_pow2, $onehot(cap_r))
  `LPHT_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_value_r))

endmodule

// ===== test/linear_probe_hash_table_core_tb.sv =====
`timescale 1ns / 1ps

module linear_probe_hash_table_core_tb;
  import lpht_pkg::*;

  localparam int CAP_MAX  = MAX_CAPACITY_DEF;
  localparam int CAP_INIT = INITIAL_CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic        found;
    logic [63:0] value;
    logic        status;
  } lookup_t;

  typedef struct {
    logic        op;
    logic [63:0] key;
    logic [31:0] hash;
    logic [63:0] value;
    logic        typed;
    lookup_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = REQ_PUT;
  logic [63:0] in_key_word = '0;
  logic [31:0] in_key_hash = '0;
  logic [63:0] in_value_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_key_found;
  logic [63:0] out_value_out;
  logic        out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  linear_probe_hash_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_key_word(in_key_word), .in_key_hash(in_key_hash), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_key_found(out_key_found),
    .out_value_out(out_value_out), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [63:0] tbl_key [CAP_MAX];
  logic [63:0] tbl_val [CAP_MAX];
  logic [31:0] tbl_hash [CAP_MAX];
  logic        tbl_used [CAP_MAX];
  int unsigned tbl_cap;
  int unsigned tbl_count;
  int unsigned tbl_load;

  lookup_t pending_lookups[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      hold_off = 1'b0;
  int      rx_long_hold = 0;

  logic [63:0] key_pool [16];
  logic [31:0] hash_pool [16];

  function automatic void table_clear();
    for (int i = 0; i < CAP_MAX; i++) tbl_used[i] = 1'b0;
    tbl_cap = CAP_INIT;
    tbl_count = 0;
  endfunction

  function automatic void table_grow(int unsigned ncap);
    logic [63:0] nk [CAP_MAX];
    logic [63:0] nv [CAP_MAX];
    logic [31:0] nh [CAP_MAX];
    logic        nu [CAP_MAX];
    int unsigned j;
    for (int i = 0; i < CAP_MAX; i++) nu[i] = 1'b0;
    for (int i = 0; i < tbl_cap; i++) begin
      if (tbl_used[i]) begin
        j = tbl_hash[i] % ncap;
        while (nu[j]) j = (j + 1) % ncap;
        nu[j] = 1'b1;
        nk[j] = tbl_key[i];
        nv[j] = tbl_val[i];
        nh[j] = tbl_hash[i];
      end
    end
    for (int i = 0; i < CAP_MAX; i++) begin
      tbl_used[i] = nu[i];
      tbl_key[i] = nk[i];
      tbl_val[i] = nv[i];
      tbl_hash[i] = nh[i];
    end
    tbl_cap = ncap;
  endfunction

  function automatic lookup_t table_access(logic op, logic [63:0] key, logic [31:0] hash,
                                           logic [63:0] value);
    lookup_t r;
    int unsigned idx;
    int unsigned n;
    r = '0;
    if (op == REQ_PUT) begin
      if ((tbl_count + 1) * 100 > tbl_cap * tbl_load && tbl_cap * 2 <= CAP_MAX)
        table_grow(tbl_cap * 2);
      idx = hash % tbl_cap;
      for (n = 0; n < tbl_cap; n++) begin
        if (!tbl_used[idx]) begin
          tbl_used[idx] = 1'b1;
          tbl_key[idx] = key;
          tbl_val[idx] = value;
          tbl_hash[idx] = hash;
          tbl_count++;
          break;
        end
        if (tbl_key[idx] == key) begin
          tbl_val[idx] = value;
          r.found = 1'b1;
          break;
        end
        idx = (idx + 1) % tbl_cap;
      end
      if (n == tbl_cap) r.status = 1'b1;
    end else begin
      idx = hash % tbl_cap;
      for (n = 0; n < tbl_cap && tbl_used[idx]; n++) begin
        if (tbl_key[idx] == key) begin
          r.found = 1'b1;
          r.value = tbl_val[idx];
          break;
        end
        idx = (idx + 1) % tbl_cap;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_key_found !== want.found) begin
          $error("key_found expected %0h actual %0h", want.found, out_key_found);
          errors++;
        end
        if (out_value_out !== want.value) begin
          $error("value_out expected %0h actual %0h", want.value, out_value_out);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0h actual %0h", want.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int i = 0; i < rx_long_hold; i++) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_word(logic op, logic [63:0] key, logic [31:0] hash, logic [63:0] value,
                           bit typed, lookup_t want, int gap);
    lookup_t got;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= op;
    in_key_word <= key;
    in_key_hash <= hash;
    in_value_in <= value;
    got = table_access(op, key, hash, value);
    if (typed && got !== want) begin
      $error("table row expected %0h computed %0h", want, got);
      errors++;
    end
    pending_lookups.push_back(got);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_load(logic [6:0] pct);
    cfg_valid <= 1'b1;
    cfg_data <= pct;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tbl_load = pct;
  endtask

  task automatic random_phase(int count, int keys_used);
    logic op;
    logic [63:0] key;
    logic [31:0] hash;
    int k;
    int gap;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(0, 1);
      k = $urandom_range(0, keys_used - 1);
      if ($urandom_range(0, 9) == 0) begin
        key = rand64();
        hash = $urandom;
      end else begin
        key = key_pool[k];
        hash = hash_pool[k];
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      send_word(op, key, hash, rand64(), 1'b0, '0, gap);
    end
  endtask

  row_t rows[$];

  initial begin
    row_t r;
    tbl_load = LOAD_RESET;
    table_clear();
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = rand64();
      hash_pool[i] = (i < 8) ? $urandom_range(0, 3) : $urandom;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    hash_pool[1] = '1;

    rows.push_back('{REQ_GET, 64'h0, 32'h0, 64'h0, 1'b1, '{1'b0, 64'h0, 1'b0}});
    rows.push_back('{REQ_PUT, 64'h0, 32'h0, 64'h0, 1'b1, '{1'b0, 64'h0, 1'b0}});
    rows.push_back('{REQ_PUT, '1, '1, '1, 1'b1, '{1'b0, 64'h0, 1'b0}});
    rows.push_back('{REQ_GET, '1, '1, 64'h0, 1'b1, '{1'b1, '1, 1'b0}});
    rows.push_back('{REQ_PUT, '1, '1, 64'h5a5a, 1'b1, '{1'b1, 64'h0, 1'b0}});
    rows.push_back('{REQ_GET, '1, '1, 64'h0, 1'b1, '{1'b1, 64'h5a5a, 1'b0}});
    rows.push_back('{REQ_GET, 64'h0, 32'h0, '1, 1'b1, '{1'b1, 64'h0, 1'b0}});
    rows.push_back('{REQ_GET, 64'h1234, 32'h7, 64'h0, 1'b1, '{1'b0, 64'h0, 1'b0}});
    for (int i = 0; i < 10; i++) begin
      r = '{REQ_PUT, rand64(), 32'h3, rand64(), 1'b0, '0};
      rows.push_back(r);
      rows.push_back('{REQ_GET, r.key, 32'h3 + 32'h8, 64'h0, 1'b0, '0});
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i].op, rows[i].key, rows[i].hash, rows[i].value,
                                rows[i].typed, rows[i].want, $urandom_range(0, 3));
    drain();

    write_load(7'd100);
    random_phase(150, 16);

    rx_long_hold = 300;
    hold_off = 1'b1;
    random_phase(40, 16);
    drain();

    write_load(7'd1);
    random_phase(120, 16);
    drain();

    write_load(7'd0);
    for (int i = 0; i < 60; i++)
      send_word(REQ_PUT, rand64(), $urandom, rand64(), 1'b0, '0, $urandom_range(0, 2));
    drain();

    write_load(7'd127);
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = rand64();
      hash_pool[i] = $urandom;
    end
    random_phase(200, 16);
    drain();

    write_load(7'd50);
    random_phase(120, 16);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
